FILE: design/huffman_tree_walk_decoder_macros.svh
// Assertion macros used by the tree walk decoder back end.
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tree walk decoder assertion failed");

// Next-cycle implication, checked outside reset.
`define HTW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tree walk decoder assertion failed");

`endif

FILE: design/htw_pkg.sv
// Shared constants, types and helpers of the tree walk decoder.
package htw_pkg;

	localparam int TABLE_NODES = 512;
	localparam int SYMBOL_BITS = 8;
	localparam int NODE_AW = $clog2(TABLE_NODES);
	localparam int IDX_W = 9;
	localparam int TOTAL_W = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_DECODE = 2'd1;
	localparam logic [1:0] CMD_END = 2'd2;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_DECODE = 2'd1;
	localparam logic [1:0] OP_END = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT_NODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_TOTAL = 1'd1;

	localparam logic [3:0] MAX_BITS = 4'd8;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic leaf;
		logic [SYMBOL_BITS-1:0] sym;
	} node_t;

	typedef struct packed {
		logic [1:0] op;
		logic [IDX_W-1:0] node_index;
		node_t node;
		logic [7:0] data_byte;
		logic [3:0] bit_count;
	} req_t;

	function automatic logic in_table(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(TABLE_NODES);
	endfunction

	function automatic logic [NODE_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
		return NODE_AW'(idx);
	endfunction

endpackage

FILE: design/htw_front.sv
// Front end: accepts commands, classifies them and saturates the bit count.
module htw_front import htw_pkg::*; (
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] command,
	input logic [IDX_W-1:0] node_index,
	input logic [IDX_W-1:0] left_child,
	input logic [IDX_W-1:0] right_child,
	input logic is_leaf,
	input logic [SYMBOL_BITS-1:0] leaf_symbol,
	input logic [7:0] data_byte,
	input logic [3:0] valid_bits,
	input logic q_full,
	output logic q_push,
	output req_t q_req
);

	logic accept;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	// The unused command is taken and dropped here.
	always_comb begin
		q_req = '0;
		q_push = 1'b0;
		q_req.node_index = node_index;
		q_req.node.left = left_child;
		q_req.node.right = right_child;
		q_req.node.leaf = is_leaf;
		q_req.node.sym = leaf_symbol;
		q_req.data_byte = data_byte;
		q_req.bit_count = (valid_bits > MAX_BITS) ? MAX_BITS : valid_bits;
		case (command)
			CMD_LOAD: begin
				q_req.op = OP_LOAD;
				q_push = accept;
			end
			CMD_DECODE: begin
				q_req.op = OP_DECODE;
				q_push = accept;
			end
			CMD_END: begin
				q_req.op = OP_END;
				q_push = accept;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/htw_queue.sv
// Short request queue between the front end and the tree walker.
module htw_queue import htw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input req_t push_req,
	output logic full,
	output logic q_valid,
	output req_t q_req,
	input logic pop
);

	req_t entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_req = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/htw_back.sv
// Back end: node table, tree walk sequencer, result holding and output register.
`include "huffman_tree_walk_decoder_macros.svh"

module htw_back import htw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic q_valid,
	input req_t q_req,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [SYMBOL_BITS-1:0] symbol,
	output logic status,
	output logic image_done,
	output logic last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BIT = 3'd1;
	localparam logic [2:0] ST_CUR = 3'd2;
	localparam logic [2:0] ST_NXT = 3'd3;
	localparam logic [2:0] ST_CLOSE = 3'd4;

	logic [2:0] state_q;
	logic [IDX_W-1:0] root_q;
	logic [TOTAL_W-1:0] total_q;
	logic [IDX_W-1:0] walk_q;
	logic [TOTAL_W-1:0] emitted_q;
	node_t cur_q;
	logic cur_valid_q;
	logic [7:0] byte_q;
	logic [3:0] rem_q;
	logic [IDX_W-1:0] child_q;

	logic pend_valid_q;
	logic [SYMBOL_BITS-1:0] pend_sym_q;
	logic pend_status_q;
	logic pend_done_q;

	logic out_valid_q;
	logic [SYMBOL_BITS-1:0] out_sym_q;
	logic out_status_q;
	logic out_done_q;
	logic out_last_q;

	node_t mem [TABLE_NODES];
	node_t rd_data_q;
	logic rd_oob_q;

	logic out_free;
	logic out_fill;
	logic padded;
	logic [TOTAL_W-1:0] emitted_inc;
	logic [IDX_W-1:0] next_child;
	node_t rd_entry;
	logic rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic wr_en;

	assign out_free = !out_valid_q || !out_stall;
	assign padded = (emitted_q >= total_q);
	assign emitted_inc = emitted_q + 1'b1;
	assign next_child = byte_q[7] ? cur_q.right : cur_q.left;
	assign rd_entry = rd_oob_q ? '0 : rd_data_q;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign wr_en = q_pop && (q_req.op == OP_LOAD) && in_table(q_req.node_index);

	// The held result moves to the output register on a new leaf or at the close.
	assign out_fill = pend_valid_q && out_free
		&& (((state_q == ST_NXT) && rd_entry.leaf) || (state_q == ST_CLOSE));

	// A step reads the current node when it is not cached, else the chosen child.
	always_comb begin
		rd_en = (state_q == ST_BIT) && (rem_q != '0) && !padded;
		rd_idx = cur_valid_q ? next_child : walk_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[to_addr(q_req.node_index)] <= q_req.node;
		end
		if (rd_en) begin
			rd_data_q <= mem[to_addr(rd_idx)];
			rd_oob_q <= !in_table(rd_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			root_q <= '0;
			total_q <= '0;
			walk_q <= '0;
			emitted_q <= '0;
			cur_q <= '0;
			cur_valid_q <= 1'b0;
			byte_q <= '0;
			rem_q <= '0;
			child_q <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q <= '0;
			pend_status_q <= 1'b0;
			pend_done_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_sym_q <= '0;
			out_status_q <= 1'b0;
			out_done_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (out_fill) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_req.op)
							OP_LOAD: begin
								cur_valid_q <= 1'b0;
							end
							OP_DECODE: begin
								byte_q <= q_req.data_byte;
								rem_q <= q_req.bit_count;
								state_q <= ST_BIT;
							end
							OP_END: begin
								if (emitted_q < total_q) begin
									pend_valid_q <= 1'b1;
									pend_sym_q <= '0;
									pend_status_q <= 1'b1;
									pend_done_q <= 1'b0;
								end
								walk_q <= root_q;
								emitted_q <= '0;
								cur_valid_q <= 1'b0;
								state_q <= ST_CLOSE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_BIT: begin
					if ((rem_q == '0) || padded) begin
						state_q <= ST_CLOSE;
					end else if (!cur_valid_q) begin
						state_q <= ST_CUR;
					end else begin
						child_q <= next_child;
						state_q <= ST_NXT;
					end
				end
				ST_CUR: begin
					cur_q <= rd_entry;
					cur_valid_q <= 1'b1;
					state_q <= ST_BIT;
				end
				ST_NXT: begin
					if (rd_entry.leaf) begin
						// The held result is known not to be the last one now.
						if (!pend_valid_q || out_free) begin
							if (pend_valid_q) begin
								out_sym_q <= pend_sym_q;
								out_status_q <= pend_status_q;
								out_done_q <= pend_done_q;
								out_last_q <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_sym_q <= rd_entry.sym;
							pend_status_q <= 1'b0;
							pend_done_q <= (emitted_inc == total_q);
							emitted_q <= emitted_inc;
							walk_q <= root_q;
							cur_valid_q <= 1'b0;
							byte_q <= {byte_q[6:0], 1'b0};
							rem_q <= rem_q - 1'b1;
							state_q <= ST_BIT;
						end
					end else begin
						walk_q <= child_q;
						cur_q <= rd_entry;
						cur_valid_q <= 1'b1;
						byte_q <= {byte_q[6:0], 1'b0};
						rem_q <= rem_q - 1'b1;
						state_q <= ST_BIT;
					end
				end
				ST_CLOSE: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_sym_q <= pend_sym_q;
						out_status_q <= pend_status_q;
						out_done_q <= pend_done_q;
						out_last_q <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					REG_ROOT_NODE: begin
						root_q <= cfg_data[IDX_W-1:0];
						walk_q <= cfg_data[IDX_W-1:0];
						cur_valid_q <= 1'b0;
					end
					REG_SYMBOL_TOTAL: begin
						total_q <= cfg_data[TOTAL_W-1:0];
					end
					default: begin
						total_q <= total_q;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign symbol = out_sym_q;
	assign status = out_status_q;
	assign image_done = out_done_q;
	assign last = out_last_q;

	`HTW_ASSERT_IMP(a_idle_no_pending, clk, arst_n, state_q == ST_IDLE, !pend_valid_q)
	`HTW_ASSERT_NXT(a_child_after_issue, clk, arst_n,
		(state_q == ST_BIT) && cur_valid_q && (rem_q != '0) && !padded, state_q == ST_NXT)
	`HTW_ASSERT_IMP(a_status_is_last, clk, arst_n, out_valid_q && out_status_q,
		out_last_q && (out_sym_q == '0))
	`HTW_ASSERT_NXT(a_cur_fill, clk, arst_n, state_q == ST_CUR, cur_valid_q)

endmodule

FILE: design/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree walk decoder.
//
//   Channel   Direction  Handshake            Carries
//   input     in         in_valid / in_stall  one command: load node, decode byte, end
//   output    out        out_valid/out_stall  one result: symbol, status, image_done, last
//   config    in         cfg_we               root_node (index 0), symbol_total (index 1)
//
// A decoded byte spends, per coded bit, a child read and then the leaf test, with
// a read of the current node first whenever it is not cached (after each emitted
// symbol, a load or a root write), plus an entry step and the close state. The
// serial chain of dependent node table reads limits the decode rate. A load is
// handled in the idle state; an end passes through the close state.
// Reset clears the walk, the counters, the queue and the output; the node table
// is not cleared and must be loaded before it is walked.
// The front end takes a request whenever the two-entry queue has room, so input
// keeps flowing while the walker waits on a stalled output register.
module huffman_tree_walk_decoder import htw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] command,
	input logic [IDX_W-1:0] node_index,
	input logic [IDX_W-1:0] left_child,
	input logic [IDX_W-1:0] right_child,
	input logic is_leaf,
	input logic [SYMBOL_BITS-1:0] leaf_symbol,
	input logic [7:0] data_byte,
	input logic [3:0] valid_bits,
	output logic out_valid,
	input logic out_stall,
	output logic [SYMBOL_BITS-1:0] symbol,
	output logic status,
	output logic image_done,
	output logic last
);

	logic q_full;
	logic q_push;
	req_t push_req;
	logic q_valid;
	req_t head_req;
	logic q_pop;

	// Classification of each request and input flow control.
	htw_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.node_index(node_index),
		.left_child(left_child),
		.right_child(right_child),
		.is_leaf(is_leaf),
		.leaf_symbol(leaf_symbol),
		.data_byte(data_byte),
		.valid_bits(valid_bits),
		.q_full(q_full),
		.q_push(q_push),
		.q_req(push_req)
	);

	// Decouples request intake from the tree walk.
	htw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_req(push_req),
		.full(q_full),
		.q_valid(q_valid),
		.q_req(head_req),
		.pop(q_pop)
	);

	// Node table, walk sequencer and the output register.
	htw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_valid(q_valid),
		.q_req(head_req),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.symbol(symbol),
		.status(status),
		.image_done(image_done),
		.last(last)
	);

endmodule
